/* hw/rtl/sfr_pkg.sv */
// Shared definitions for the sequenced frame reassembler.
// Holds sizes, register indices, status codes, the controller/datapath
// interface structs and the ring pointer helper. No dependencies.
`timescale 1ns / 1ps

package sfr_pkg;

  // Byte slots per receive ring (one slot is always kept free).
  localparam int RING_DEPTH = 256;
  localparam int PTR_W      = $clog2(RING_DEPTH);
  localparam int ADDR_W     = PTR_W + 1;
  localparam int MEM_WORDS  = 2 ** ADDR_W;

  localparam int ID_W       = 29;
  localparam int SEQ_W      = 8;
  localparam int TIME_W     = 32;
  localparam int SIZE_W     = 4;
  localparam int PAYLOAD_W  = 64;
  localparam int BYTE_W     = 8;
  localparam int CFG_W      = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int MAX_BYTES  = 8;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_STREAM0_BASE    = 2'd0,
    REG_STREAM1_BASE    = 2'd1,
    REG_SEQ_MASK        = 2'd2,
    REG_SILENCE_TIMEOUT = 2'd3
  } cfg_reg_t;

  typedef enum logic [1:0] {
    ST_NONE     = 2'd0,
    ST_STORED   = 2'd1,
    ST_BAD_SEQ  = 2'd2,
    ST_OVERFLOW = 2'd3
  } frame_status_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_item;
    logic classify;
    logic read_step;
    logic check;
    logic write_step;
    logic finalize;
    logic emit;
  } sfr_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_read;
    logic hit;
    logic seq_match;
    logic write_done;
    logic ring_full;
    logic out_free;
  } sfr_stat_t;

  function automatic logic [PTR_W-1:0] ring_next(input logic [PTR_W-1:0] p);
    logic [PTR_W-1:0] r;
    if (p == PTR_W'(RING_DEPTH - 1)) begin
      r = '0;
    end else begin
      r = p + 1'b1;
    end
    return r;
  endfunction

endpackage

/* hw/rtl/sfr_ctrl.sv */
// Controller state machine of the sequenced frame reassembler.
// Sequences classify, sequence check, byte writes, reads and result hand-off.
// Depends on sfr_pkg.
`timescale 1ns / 1ps

module sfr_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  output sfr_pkg::sfr_cmd_t cmd,
  input  sfr_pkg::sfr_stat_t stat
);
  import sfr_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE     = 5'b00001,
    S_CLASSIFY = 5'b00010,
    S_CHECK    = 5'b00100,
    S_WRITE    = 5'b01000,
    S_FINISH   = 5'b10000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_item = 1'b1;
          state_next    = S_CLASSIFY;
        end
      end
      S_CLASSIFY: begin
        if (stat.is_read) begin
          cmd.read_step = 1'b1;
          state_next    = S_FINISH;
        end else begin
          cmd.classify = 1'b1;
          state_next   = S_CHECK;
        end
      end
      S_CHECK: begin
        cmd.check = 1'b1;
        if (stat.hit && stat.seq_match) begin
          state_next = S_WRITE;
        end else begin
          state_next = S_FINISH;
        end
      end
      S_WRITE: begin
        if (stat.write_done || stat.ring_full) begin
          cmd.finalize = 1'b1;
          state_next   = S_FINISH;
        end else begin
          cmd.write_step = 1'b1;
        end
      end
      S_FINISH: begin
        if (stat.out_free) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

/* hw/rtl/sfr_datapath.sv */
// Datapath of the sequenced frame reassembler: configuration registers,
// per-stream pointers, sequence and deadline state, the byte ring memory
// and the result register. Depends on sfr_pkg.
`timescale 1ns / 1ps

module sfr_datapath (
  input  logic                          clk,
  input  logic                          rst,
  input  sfr_pkg::sfr_cmd_t             cmd,
  output sfr_pkg::sfr_stat_t            stat,
  input  logic                          cfg_we,
  input  logic [sfr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [sfr_pkg::CFG_W-1:0]     cfg_data,
  input  logic                          kind,
  input  logic                          channel,
  input  logic [sfr_pkg::ID_W-1:0]      frame_id,
  input  logic [sfr_pkg::SIZE_W-1:0]    frame_size,
  input  logic [sfr_pkg::PAYLOAD_W-1:0] payload,
  input  logic [sfr_pkg::TIME_W-1:0]    now,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [1:0]                    frame_status,
  output logic [sfr_pkg::SIZE_W-1:0]    bytes_stored,
  output logic                          read_valid,
  output logic [sfr_pkg::BYTE_W-1:0]    read_byte,
  output logic                          overflow_sticky
);
  import sfr_pkg::*;

  // Configuration.
  logic [ID_W-1:0]   cfg_base0, cfg_base1;
  logic [SEQ_W-1:0]  cfg_seq_mask;
  logic [TIME_W-1:0] cfg_timeout;

  // Latched item.
  logic                 it_kind, it_channel;
  logic [ID_W-1:0]      it_id;
  logic [SIZE_W-1:0]    it_size;
  logic [PAYLOAD_W-1:0] it_payload;
  logic [TIME_W-1:0]    it_now;

  // Stream state.
  logic [PTR_W-1:0]  wr_ptr [2];
  logic [PTR_W-1:0]  rd_ptr [2];
  logic [SEQ_W-1:0]  expected_seq [2];
  logic [TIME_W-1:0] deadline [2];
  logic              overflow_flag;

  // Classification and progress.
  logic              hit, strm;
  logic [SEQ_W-1:0]  offset;
  logic [SIZE_W-1:0] count;
  logic [1:0]        res_status;
  logic              res_rvalid;

  // Ring memory, both streams side by side.
  logic [BYTE_W-1:0] ring_mem [MEM_WORDS];
  logic [BYTE_W-1:0] mem_q;

  logic [ID_W:0]     diff0, diff1;
  logic              in0, in1;
  logic              expired;
  logic [SEQ_W-1:0]  exp_eff;
  logic [PTR_W-1:0]  wr_next;
  logic              read_avail;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_base0    <= ID_W'(256);
      cfg_base1    <= ID_W'(272);
      cfg_seq_mask <= SEQ_W'(15);
      cfg_timeout  <= TIME_W'(100);
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_STREAM0_BASE:    cfg_base0    <= cfg_data[ID_W-1:0];
        REG_STREAM1_BASE:    cfg_base1    <= cfg_data[ID_W-1:0];
        REG_SEQ_MASK:        cfg_seq_mask <= cfg_data[SEQ_W-1:0];
        REG_SILENCE_TIMEOUT: cfg_timeout  <= cfg_data[TIME_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Range match against each base: no borrow and offset within the mask.
  assign diff0 = {1'b0, it_id} - {1'b0, cfg_base0};
  assign diff1 = {1'b0, it_id} - {1'b0, cfg_base1};
  assign in0   = !diff0[ID_W] && (diff0[ID_W-1:0] <= ID_W'(cfg_seq_mask));
  assign in1   = !diff1[ID_W] && (diff1[ID_W-1:0] <= ID_W'(cfg_seq_mask));

  assign expired    = deadline[strm] < it_now;
  assign exp_eff    = expired ? offset : expected_seq[strm];
  assign wr_next    = ring_next(wr_ptr[strm]);
  assign read_avail = rd_ptr[it_channel] != wr_ptr[it_channel];

  assign stat.is_read    = it_kind;
  assign stat.hit        = hit;
  assign stat.seq_match  = offset == exp_eff;
  assign stat.write_done = count == it_size;
  assign stat.ring_full  = wr_next == rd_ptr[strm];
  assign stat.out_free   = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      it_kind    <= kind;
      it_channel <= channel;
      it_id      <= frame_id;
      it_size    <= (frame_size > SIZE_W'(MAX_BYTES)) ? SIZE_W'(MAX_BYTES) : frame_size;
      it_payload <= payload;
      it_now     <= now;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.classify) begin
      hit    <= in0 || in1;
      strm   <= !in0;
      offset <= in0 ? diff0[SEQ_W-1:0] : diff1[SEQ_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int s = 0; s < 2; s++) begin
        wr_ptr[s]       <= '0;
        rd_ptr[s]       <= '0;
        expected_seq[s] <= '0;
        deadline[s]     <= '0;
      end
      overflow_flag <= 1'b0;
      count         <= '0;
      res_status    <= ST_NONE;
      res_rvalid    <= 1'b0;
    end else begin
      if (cmd.load_item) begin
        count      <= '0;
        res_status <= ST_NONE;
        res_rvalid <= 1'b0;
      end
      if (cmd.read_step) begin
        res_rvalid <= read_avail;
        if (read_avail) begin
          rd_ptr[it_channel] <= ring_next(rd_ptr[it_channel]);
        end
      end
      if (cmd.check && hit) begin
        if (expired) begin
          expected_seq[strm] <= offset;
        end
        if (offset != exp_eff) begin
          res_status <= ST_BAD_SEQ;
        end
      end
      if (cmd.write_step) begin
        wr_ptr[strm] <= wr_next;
        count        <= count + 1'b1;
      end
      if (cmd.finalize) begin
        if (stat.write_done) begin
          res_status <= ST_STORED;
        end else begin
          res_status    <= ST_OVERFLOW;
          overflow_flag <= 1'b1;
        end
        expected_seq[strm] <= SEQ_W'(expected_seq[strm] + 1'b1) & cfg_seq_mask;
        deadline[strm]     <= it_now + cfg_timeout;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.write_step) begin
      ring_mem[{strm, wr_ptr[strm]}] <= it_payload[{count[2:0], 3'b000} +: BYTE_W];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.read_step) begin
      mem_q <= ring_mem[{it_channel, rd_ptr[it_channel]}];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid       <= 1'b0;
      frame_status    <= ST_NONE;
      bytes_stored    <= '0;
      read_valid      <= 1'b0;
      read_byte       <= '0;
      overflow_sticky <= 1'b0;
    end else if (cmd.emit) begin
      out_valid       <= 1'b1;
      frame_status    <= res_status;
      bytes_stored    <= count;
      read_valid      <= res_rvalid;
      read_byte       <= res_rvalid ? mem_q : '0;
      overflow_sticky <= overflow_flag;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

endmodule

/* hw/rtl/sequenced_frame_reassembler_core.sv */
// Top level of the sequenced frame reassembler.
// Joins the controller (sfr_ctrl) and the datapath (sfr_datapath).
// Depends on sfr_pkg.
`timescale 1ns / 1ps

// The block turns numbered bus frames into two receive byte streams. A frame transfer
// (kind 0) whose id lies within stream0_base_id .. stream0_base_id + sequence_mask belongs
// to stream 0, otherwise within the same window above stream1_base_id to stream 1, and is
// otherwise ignored with status 0. The id's offset from its base is a rolling sequence
// number; if the stream's deadline lies strictly before now, the expected number is first
// resynchronised to it. A frame with the expected number has up to eight payload bytes
// (sizes above eight count as eight) appended to the stream's ring of RING_DEPTH bytes, of
// which RING_DEPTH - 1 can be held; bytes that do not fit are dropped, the status becomes
// 3 and the overflow flag is set for good. A frame with any other number gets status 2.
// After an accepted frame the sequence advances and the deadline becomes now plus
// silence_timeout. A read transfer (kind 1) pops one byte from the ring named by channel.
// Every input transfer yields exactly one result transfer. Items are handled one at a
// time: a frame with the expected number goes through the classify, check and write
// states, the write state storing one byte a cycle into the ring memory; a frame that is
// not ours or out of sequence skips the write state, and a read goes from classify
// straight to hand-off. The hand-off waits while the previous result is not collected.
// The result sits in an output register, so the next item is taken while it waits to be
// collected. Configuration registers are written through cfg_we, cfg_index and cfg_data;
// the user must write them only while the block is idle, which the block does not enforce.

module sequenced_frame_reassembler_core (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [sfr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [sfr_pkg::CFG_W-1:0]     cfg_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          kind,
  input  logic                          channel,
  input  logic [sfr_pkg::ID_W-1:0]      frame_id,
  input  logic [sfr_pkg::SIZE_W-1:0]    frame_size,
  input  logic [sfr_pkg::PAYLOAD_W-1:0] payload,
  input  logic [sfr_pkg::TIME_W-1:0]    now,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [1:0]                    frame_status,
  output logic [sfr_pkg::SIZE_W-1:0]    bytes_stored,
  output logic                          read_valid,
  output logic [sfr_pkg::BYTE_W-1:0]    read_byte,
  output logic                          overflow_sticky
);
  import sfr_pkg::*;

  // Commands and status are the only coupling between the two halves.
  sfr_cmd_t  cmd;
  sfr_stat_t stat;

  sfr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .cmd      (cmd),
    .stat     (stat)
  );

  sfr_datapath u_datapath (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .stat            (stat),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .kind            (kind),
    .channel         (channel),
    .frame_id        (frame_id),
    .frame_size      (frame_size),
    .payload         (payload),
    .now             (now),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .frame_status    (frame_status),
    .bytes_stored    (bytes_stored),
    .read_valid      (read_valid),
    .read_byte       (read_byte),
    .overflow_sticky (overflow_sticky)
  );

endmodule

/* hw/rtl/sfr_checker.sv */
// Port-level checks for the sequenced frame reassembler, bound to the top level.
// Depends on sfr_pkg and sequenced_frame_reassembler_core.
`timescale 1ns / 1ps

module sfr_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [1:0]                    frame_status,
  input logic [sfr_pkg::SIZE_W-1:0]    bytes_stored,
  input logic                          read_valid,
  input logic [sfr_pkg::BYTE_W-1:0]    read_byte,
  input logic                          overflow_sticky
);
  import sfr_pkg::*;

  // A stalled result holds still.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(frame_status) &&
      $stable(bytes_stored) && $stable(read_valid) && $stable(read_byte))
    else $error("result changed while stalled");

  // The overflow flag is never cleared once shown.
  a_sticky: assert property (@(posedge clk) disable iff (rst)
    !$fell(overflow_sticky))
    else $error("overflow flag cleared");

  // A result carries either frame outcome or read outcome, never both.
  a_exclusive: assert property (@(posedge clk) disable iff (rst)
    out_valid && read_valid |-> frame_status == ST_NONE && bytes_stored == '0)
    else $error("read result with frame status");

  // Dropped or foreign frames store nothing, and no more than eight bytes are stored.
  a_stored: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> bytes_stored <= SIZE_W'(MAX_BYTES) &&
      ((frame_status != ST_NONE && frame_status != ST_BAD_SEQ) || bytes_stored == '0))
    else $error("bad stored byte count");

  // An empty read returns a zero byte.
  a_empty_read: assert property (@(posedge clk) disable iff (rst)
    out_valid && !read_valid |-> read_byte == '0)
    else $error("byte on empty read");

endmodule

bind sequenced_frame_reassembler_core sfr_checker u_sfr_checker (.*);

/* verif/tb.sv */
// Self-checking testbench for sequenced_frame_reassembler_core.
// Holds its own model of the two receive rings and drives directed and random transfers.
// Depends on sfr_pkg and the RTL of the core.
`timescale 1ns / 1ps

module tb;
  import sfr_pkg::*;

  // Kinds of input transfer.
  localparam logic KIND_FRAME = 1'b0;
  localparam logic KIND_READ  = 1'b1;

  // Cycles without any accepted transfer before the run is abandoned.
  localparam int QUIET_LIMIT = 3000;
  // Cycles allowed for the core to come to rest.
  localparam int SETTLE_CYCLES = 16;
  localparam int REPORT_LIMIT = 10;

  // One input transfer, field for field as on the ports.
  typedef struct packed {
    logic                 kind;
    logic                 channel;
    logic [ID_W-1:0]      id;
    logic [SIZE_W-1:0]    size;
    logic [PAYLOAD_W-1:0] payload;
    logic [TIME_W-1:0]    stamp;
  } frame_item_t;

  // One result transfer.
  typedef struct packed {
    frame_status_t     status;
    logic [SIZE_W-1:0] stored;
    logic              rvalid;
    logic [BYTE_W-1:0] rbyte;
    logic              ovf;
  } reassembly_result_t;

  // A row of the directed table. Where typed is set, res is the result read off by hand.
  typedef struct packed {
    frame_item_t        it;
    bit                 typed;
    reassembly_result_t res;
  } stim_row_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data = '0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic                 kind = 1'b0;
  logic                 channel = 1'b0;
  logic [ID_W-1:0]      frame_id = '0;
  logic [SIZE_W-1:0]    frame_size = '0;
  logic [PAYLOAD_W-1:0] payload = '0;
  logic [TIME_W-1:0]    now = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [1:0]           frame_status;
  logic [SIZE_W-1:0]    bytes_stored;
  logic                 read_valid;
  logic [BYTE_W-1:0]    read_byte;
  logic                 overflow_sticky;

  sequenced_frame_reassembler_core dut (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .kind           (kind),
    .channel        (channel),
    .frame_id       (frame_id),
    .frame_size     (frame_size),
    .payload        (payload),
    .now            (now),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .frame_status   (frame_status),
    .bytes_stored   (bytes_stored),
    .read_valid     (read_valid),
    .read_byte      (read_byte),
    .overflow_sticky(overflow_sticky)
  );

  // 12 ns period.
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------------------
  // Model of the core. Its copy of the registers follows every write that the testbench
  // makes; its rings, pointers, sequence counters and deadlines follow every accepted input
  // transfer, in the order of acceptance.
  // ---------------------------------------------------------------------------------------
  logic [ID_W-1:0]   base_id [2];
  logic [SEQ_W-1:0]  seq_mask;
  logic [TIME_W-1:0] timeout;

  logic [BYTE_W-1:0] ring_mem [2][RING_DEPTH];
  logic [PTR_W-1:0]  wr_ptr [2];
  logic [PTR_W-1:0]  rd_ptr [2];
  logic [SEQ_W-1:0]  next_seq [2];
  logic [TIME_W-1:0] stream_deadline [2];
  logic              sticky_ovf;

  // Results still owed by the core, oldest first.
  reassembly_result_t owed_results [$];

  int  mismatch_count = 0;
  int  quiet_cycles = 0;
  int  stall_left = 0;
  bit  idling_on = 1'b1;
  logic [TIME_W-1:0] stamp_clock = '0;

  // Works out the result of one accepted transfer and moves the model on.
  function automatic reassembly_result_t reassemble(input frame_item_t it);
    reassembly_result_t r;
    int                 s;
    int                 take;
    logic [SEQ_W-1:0]   offset;
    logic [PTR_W-1:0]   nx;
    r = '0;
    r.status = ST_NONE;
    if (it.kind == KIND_READ) begin
      if (rd_ptr[it.channel] != wr_ptr[it.channel]) begin
        r.rvalid = 1'b1;
        r.rbyte = ring_mem[it.channel][rd_ptr[it.channel]];
        rd_ptr[it.channel] = (rd_ptr[it.channel] == PTR_W'(RING_DEPTH - 1)) ?
                             '0 : rd_ptr[it.channel] + 1'b1;
      end
    end else begin
      // The window is compared one bit wider so that a base near the top of the id range
      // does not wrap. Stream 0 is looked at first and so wins where the windows overlap.
      s = -1;
      if (it.id >= base_id[0] && {1'b0, it.id} <= {1'b0, base_id[0]} + seq_mask) begin
        s = 0;
      end else if (it.id >= base_id[1] && {1'b0, it.id} <= {1'b0, base_id[1]} + seq_mask) begin
        s = 1;
      end
      if (s >= 0) begin
        offset = SEQ_W'(it.id - base_id[s]);
        // A stream silent past its deadline takes whatever number arrives.
        if (stream_deadline[s] < it.stamp) begin
          next_seq[s] = offset;
        end
        if (offset == next_seq[s]) begin
          take = (it.size > MAX_BYTES) ? MAX_BYTES : int'(it.size);
          r.status = ST_STORED;
          for (int n = 0; n < take; n++) begin
            nx = (wr_ptr[s] == PTR_W'(RING_DEPTH - 1)) ? '0 : wr_ptr[s] + 1'b1;
            if (nx == rd_ptr[s]) begin
              r.status = ST_OVERFLOW;
              sticky_ovf = 1'b1;
              break;
            end
            ring_mem[s][wr_ptr[s]] = it.payload[8*n +: 8];
            wr_ptr[s] = nx;
            r.stored = r.stored + 1'b1;
          end
          next_seq[s] = (next_seq[s] + 1'b1) & seq_mask;
          stream_deadline[s] = it.stamp + timeout;
        end else begin
          r.status = ST_BAD_SEQ;
        end
      end
    end
    r.ovf = sticky_ovf;
    return r;
  endfunction

  // Idle stretches on either side: mostly short, now and then a long one.
  function automatic int idle_length();
    return ($urandom_range(99) < 85) ? $urandom_range(1, 3) : $urandom_range(8, 40);
  endfunction

  // ---------------------------------------------------------------------------------------
  // Input side. Each task call is entered at a clock edge and returns at the edge at which
  // its transfer was accepted, with valid still high. A following item with no gap is then
  // put on the ports at that very edge, so valid is never lowered and raised in one step.
  // ---------------------------------------------------------------------------------------
  task automatic send_item(input frame_item_t it, input bit typed,
                           input reassembly_result_t typed_res);
    int                 gap;
    reassembly_result_t modelled;
    gap = (idling_on && $urandom_range(99) < 40) ? idle_length() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    kind       <= it.kind;
    channel    <= it.channel;
    frame_id   <= it.id;
    frame_size <= it.size;
    payload    <= it.payload;
    now        <= it.stamp;
    do @(posedge clk); while (!in_ready);
    // The model always runs so that its state stays in step, even when the row carries
    // a result typed in by hand.
    modelled = reassemble(it);
    owed_results.push_back(typed ? typed_res : modelled);
  endtask

  // Waits for the core to fall idle, then writes all four registers back to back.
  task automatic program_regs(input logic [CFG_W-1:0] base0, input logic [CFG_W-1:0] base1,
                              input logic [CFG_W-1:0] mask, input logic [CFG_W-1:0] tmo);
    while (owed_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= REG_STREAM0_BASE;
    cfg_data  <= base0;
    @(posedge clk);
    base_id[0] = base0[ID_W-1:0];
    cfg_index <= REG_STREAM1_BASE;
    cfg_data  <= base1;
    @(posedge clk);
    base_id[1] = base1[ID_W-1:0];
    cfg_index <= REG_SEQ_MASK;
    cfg_data  <= mask;
    @(posedge clk);
    seq_mask = mask[SEQ_W-1:0];
    cfg_index <= REG_SILENCE_TIMEOUT;
    cfg_data  <= tmo;
    @(posedge clk);
    timeout = tmo;
    cfg_we <= 1'b0;
  endtask

  // A run of random transfers: reads, noise and frames with the number that their stream
  // expects, the last so that rings fill, drain and overflow. Noise is foreign ids, numbers
  // out of sequence and time stamps anywhere in the range.
  task automatic run_phase(input int count, input int read_pct, input int noise_pct,
                           input bit idle);
    frame_item_t        it;
    reassembly_result_t unused;
    int                 pick;
    int                 variant;
    int                 s;
    unused = '0;
    idling_on = idle;
    for (int k = 0; k < count; k++) begin
      it.kind    = KIND_FRAME;
      it.channel = 1'($urandom_range(1));
      it.id      = ID_W'($urandom);
      it.size    = SIZE_W'($urandom_range(15));
      it.payload = {$urandom, $urandom};
      if ($urandom_range(99) < 3) begin
        stamp_clock = stamp_clock + $urandom;
      end else begin
        stamp_clock = stamp_clock + $urandom_range(0, 24);
      end
      it.stamp = stamp_clock;
      s = $urandom_range(1);
      pick = $urandom_range(99);
      if (pick < read_pct) begin
        it.kind = KIND_READ;
      end else if (pick < read_pct + noise_pct) begin
        variant = $urandom_range(2);
        if (variant == 0) begin
          it.stamp = $urandom;
        end else if (variant == 1) begin
          it.id = ID_W'(base_id[s] + ($urandom_range(255) & seq_mask));
        end else begin
          it.id = ID_W'(base_id[s] + next_seq[s]);
          it.stamp = $urandom;
        end
      end else begin
        it.id = ID_W'(base_id[s] + next_seq[s]);
        variant = $urandom_range(99);
        if (variant < 10) begin
          it.size = SIZE_W'($urandom_range(9, 15));
        end else if (variant < 16) begin
          it.size = '0;
        end else begin
          it.size = SIZE_W'($urandom_range(1, 8));
        end
      end
      send_item(it, 1'b0, unused);
    end
    in_valid <= 1'b0;
  endtask

  function automatic stim_row_t frame_row(input logic [ID_W-1:0] id,
                                          input logic [SIZE_W-1:0] size,
                                          input logic [PAYLOAD_W-1:0] pl,
                                          input logic [TIME_W-1:0] stamp, input bit typed,
                                          input frame_status_t st,
                                          input logic [SIZE_W-1:0] stored);
    stim_row_t row;
    row = '0;
    row.it.kind    = KIND_FRAME;
    row.it.id      = id;
    row.it.size    = size;
    row.it.payload = pl;
    row.it.stamp   = stamp;
    row.typed      = typed;
    row.res.status = st;
    row.res.stored = stored;
    return row;
  endfunction

  function automatic stim_row_t read_row(input logic ch, input bit typed, input logic rv,
                                         input logic [BYTE_W-1:0] rb);
    stim_row_t row;
    row = '0;
    row.it.kind    = KIND_READ;
    row.it.channel = ch;
    row.typed      = typed;
    row.res.status = ST_NONE;
    row.res.rvalid = rv;
    row.res.rbyte  = rb;
    return row;
  endfunction

  // ---------------------------------------------------------------------------------------
  // Output side. Ready drops now and then for a random stretch; with idling switched off it
  // stays high. Results are compared at the edge at which they are accepted, using the
  // values that held just before that edge.
  // ---------------------------------------------------------------------------------------
  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
    end else if (!out_ready) begin
      out_ready <= 1'b1;
    end else if (idling_on && $urandom_range(99) < 25) begin
      out_ready  <= 1'b0;
      stall_left <= idle_length() - 1;
    end
  end

  always @(posedge clk) begin : result_check
    reassembly_result_t want;
    if (!rst && out_valid && out_ready) begin
      if (owed_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT) begin
          $display("%0t: result transfer with nothing owed: status %0d stored %0d",
                   $realtime, frame_status, bytes_stored);
        end
      end else begin
        want = owed_results.pop_front();
        if (frame_status !== want.status || bytes_stored !== want.stored ||
            read_valid !== want.rvalid || read_byte !== want.rbyte ||
            overflow_sticky !== want.ovf) begin
          mismatch_count++;
          if (mismatch_count <= REPORT_LIMIT) begin
            $display("%0t: expected status %0d stored %0d rvalid %0b byte %02h ovf %0b",
                     $realtime, want.status, want.stored, want.rvalid, want.rbyte, want.ovf);
            $display("%0t:   actual status %0d stored %0d rvalid %0b byte %02h ovf %0b",
                     $realtime, frame_status, bytes_stored, read_valid, read_byte,
                     overflow_sticky);
          end
        end
      end
    end
  end

  // Watchdog: the run is abandoned once no transfer has been accepted on either side for
  // too long.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------------------
  // Sequence of the run.
  // ---------------------------------------------------------------------------------------
  initial begin
    stim_row_t rows [$];

    // The model starts from the reset state with the register reset values.
    base_id[0] = ID_W'(256);
    base_id[1] = ID_W'(272);
    seq_mask   = SEQ_W'(15);
    timeout    = TIME_W'(100);
    for (int c = 0; c < 2; c++) begin
      wr_ptr[c] = '0;
      rd_ptr[c] = '0;
      next_seq[c] = '0;
      stream_deadline[c] = '0;
    end
    sticky_ovf = 1'b0;

    // Directed table, run at the reset values of the registers. Typed results are those
    // that can be read off directly: empty rings, foreign ids, plain stores, the number
    // out of sequence and the first bytes popped back.
    rows.push_back(read_row(1'b0, 1'b1, 1'b0, 8'h00));          // empty ring, stream 0
    rows.push_back(read_row(1'b1, 1'b1, 1'b0, 8'h00));          // empty ring, stream 1
    rows.push_back(frame_row('0, 4'd8, 64'h0123456789ABCDEF, '0, 1'b1, ST_NONE, 4'd0));
    rows.push_back(frame_row('1, 4'd15, '1, '1, 1'b1, ST_NONE, 4'd0));
    // First frame of stream 0, eight bytes; the deadline at zero has not passed.
    rows.push_back(frame_row(29'd256, 4'd8, 64'h8877665544332211, 32'd0, 1'b1,
                             ST_STORED, 4'd8));
    // Same number again within the deadline: out of sequence.
    rows.push_back(frame_row(29'd256, 4'd4, 64'h0, 32'd50, 1'b1, ST_BAD_SEQ, 4'd0));
    // Oversized frame counts as eight bytes.
    rows.push_back(frame_row(29'd257, 4'd15, 64'hFFEEDDCCBBAA9988, 32'd60, 1'b1,
                             ST_STORED, 4'd8));
    rows.push_back(frame_row(29'd258, 4'd0, 64'h0, 32'd100, 1'b1, ST_STORED, 4'd0));
    rows.push_back(frame_row(29'd272, 4'd1, 64'h000000000000005A, 32'd0, 1'b1,
                             ST_STORED, 4'd1));
    // Top of the stream 1 window after its deadline has passed: resynchronises.
    rows.push_back(frame_row(29'd287, 4'd2, 64'h000000000000C3A5, 32'd101, 1'b1,
                             ST_STORED, 4'd2));
    rows.push_back(frame_row(29'd288, 4'd8, '1, 32'd102, 1'b1, ST_NONE, 4'd0));
    rows.push_back(frame_row(29'd255, 4'd8, '1, 32'd103, 1'b1, ST_NONE, 4'd0));
    rows.push_back(read_row(1'b0, 1'b1, 1'b1, 8'h11));
    rows.push_back(read_row(1'b0, 1'b1, 1'b1, 8'h22));
    rows.push_back(read_row(1'b1, 1'b1, 1'b1, 8'h5A));
    rows.push_back(read_row(1'b1, 1'b1, 1'b1, 8'hA5));
    rows.push_back(read_row(1'b1, 1'b1, 1'b1, 8'hC3));
    rows.push_back(read_row(1'b1, 1'b1, 1'b0, 8'h00));
    // The latest possible time stamp; the renewed deadline wraps past zero.
    rows.push_back(frame_row(29'd259, 4'd8, 64'hDEADBEEFCAFEF00D, '1, 1'b0, ST_NONE, 4'd0));
    rows.push_back(frame_row(29'd260, 4'd3, 64'h0000000000ABCDEF, 32'd5, 1'b0,
                             ST_NONE, 4'd0));
    rows.push_back(frame_row(29'd262, 4'd5, 64'h1122334455667788, 32'd6, 1'b0,
                             ST_NONE, 4'd0));
    rows.push_back(read_row(1'b0, 1'b0, 1'b0, 8'h00));

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    idling_on = 1'b1;
    foreach (rows[r]) begin
      send_item(rows[r].it, rows[r].typed, rows[r].res);
    end
    in_valid <= 1'b0;
    stamp_clock = 32'd200;

    // Random phases, each under its own register setting. Low read rates fill the rings
    // into overflow; high ones drain them until reads find them empty.
    program_regs(32'h100, 32'h110, 32'h0F, 32'd100);
    run_phase(200, 40, 15, 1'b1);
    // Overlapping windows, and a timeout of zero so that any later frame resynchronises.
    program_regs(32'h0, 32'h5, 32'h0F, 32'd0);
    run_phase(250, 10, 15, 1'b1);
    // Extremes: the highest base, the widest mask and the longest timeout.
    program_regs(32'h1FFFFFFF, 32'h0, 32'hFF, 32'hFFFFFFFF);
    run_phase(250, 70, 15, 1'b0);
    // A mask of zero leaves a single number per stream.
    program_regs(32'h0ABCDE, 32'h0ABCE6, 32'h00, 32'd50);
    run_phase(200, 30, 20, 1'b1);
    // A mask that is not one below a power of two.
    program_regs({3'b000, 29'($urandom)}, {3'b000, 29'($urandom)}, 32'h5A, 32'd1000);
    run_phase(250, 45, 15, 1'b1);
    program_regs(32'h1000, 32'h2000, 32'h07, 32'd20);
    run_phase(280, 50, 10, 1'b0);

    // Drain, then give the core time to show any stray result.
    while (owed_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (mismatch_count == 0 && owed_results.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

/* sequenced_frame_reassembler_core.f */
hw/rtl/sfr_pkg.sv
hw/rtl/sfr_ctrl.sv
hw/rtl/sfr_datapath.sv
hw/rtl/sequenced_frame_reassembler_core.sv
hw/rtl/sfr_checker.sv
verif/tb.sv
